// File: rtl/rwcc_pkg.sv
// ----------------------------------------------------------------------------
// rwcc_pkg - shared types and constants of the RGB window color classifier
// Sequencer states, register counts and the reset values of the color boxes.
// ----------------------------------------------------------------------------
package rwcc_pkg;

    // number of color box registers on the configuration port
    localparam int NUM_REGS = 8;

    // full scale of a normalized channel
    localparam logic [7:0] FULL_SCALE = 8'hFF;

    // color index that means no box matched
    localparam logic [3:0] UNKNOWN_INDEX = 4'd8;

    // index of the first quotient bit: the saturation check
    localparam logic [3:0] TOP_STEP = 4'd8;

    // channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // color box layout: rmin, rmax, gmin, gmax, bmin, bmax from bit 0 upward
    typedef logic [47:0] bounds_t;

    // reset boxes: black, white, red, green, blue, yellow, pink, purple
    localparam bounds_t BOUNDS_RESET [NUM_REGS] = '{
        48'd54976420262400,
        48'd281238749904840,
        48'd109952840564680,
        48'd109955454100480,
        48'd281236136289280,
        48'd109955454140360,
        48'd281236136329160,
        48'd281236136329160
    };

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_MATCH = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

endpackage

// File: rtl/rgb_window_color_classifier_unit.sv
// ----------------------------------------------------------------------------
// rgb_window_color_classifier_unit - windowed RGB color classifier
// Normalizes each sensor word to the clear count, averages over a window and
// finds the first color box holding the averages, all on one shared divider.
// ----------------------------------------------------------------------------
// Sample with nonzero clear: accept, then per channel a load state and up to
//   9 restoring divide steps; a sample with clear of zero only moves the window.
// Window end averages on the same divider, compares up to COLOR_ENTRIES boxes
//   in turn and loads the output word once the output register is free.
// The shared divider, one quotient bit a cycle, sets the rate; EMIT can stall.
// Async active-low reset clears sums, counters and boxes to their defaults.
module rgb_window_color_classifier_unit
    import rwcc_pkg::*;
#(
    parameter int SAMPLES_PER_WINDOW = 10,
    parameter int COLOR_ENTRIES      = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // raw_red, raw_green, raw_blue, raw_clear
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // color_index, station_found, avg_red,
                                        // avg_green, avg_blue, valid_samples, pad
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    localparam logic [4:0] WINDOW_LEN = 5'(SAMPLES_PER_WINDOW);
    localparam logic [2:0] LAST_ENTRY = 3'(COLOR_ENTRIES - 1);

    state_t      state_reg;
    bounds_t     bounds_reg [NUM_REGS];
    logic [15:0] raw_reg [3];
    logic [15:0] clear_reg;
    logic [11:0] sum_reg [3];
    logic [7:0]  avg_reg [3];
    logic [4:0]  win_pos_reg;
    logic [4:0]  valid_cnt_reg;
    logic [1:0]  chan_reg;
    logic        avg_phase_reg;
    logic [23:0] rem_reg;
    logic [23:0] dvs_reg;
    logic [7:0]  quo_reg;
    logic [3:0]  step_reg;
    logic [2:0]  entry_reg;
    logic [3:0]  idx_reg;
    logic        out_valid_reg;
    logic [39:0] out_data_reg;

    logic        in_accept;
    logic        out_free;
    logic [15:0] raw_cur;
    logic [23:0] dividend;
    logic [23:0] divisor;
    logic        ge;
    logic [23:0] rem_sub;
    logic        chan_done;
    logic [7:0]  q_val;
    logic [4:0]  pos_inc;
    logic [4:0]  cnt_inc;
    bounds_t     box;
    logic        hit;
    logic        station;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // divider operands: raw*255/clear, or sum/count when averaging
    assign raw_cur = raw_reg[chan_reg];
    always_comb
    begin
        if (avg_phase_reg)
        begin
            dividend = {12'd0, sum_reg[chan_reg]};
            divisor  = {11'd0, valid_cnt_reg, 8'd0};
        end
        else
        begin
            dividend = {raw_cur, 8'd0} - {8'd0, raw_cur};
            divisor  = {clear_reg, 8'd0};
        end
    end

    // shared restoring divide step
    assign ge        = (rem_reg >= dvs_reg);
    assign rem_sub   = rem_reg - dvs_reg;
    assign chan_done = ((step_reg == TOP_STEP) && ge) || (step_reg == 4'd0);
    assign q_val     = (step_reg == TOP_STEP) ? FULL_SCALE : {quo_reg[6:0], ge};

    assign pos_inc = win_pos_reg + 5'd1;
    assign cnt_inc = valid_cnt_reg + 5'd1;

    // box compare for the current entry
    assign box = bounds_reg[entry_reg];
    assign hit = (avg_reg[CH_RED]   >= box[7:0])   && (avg_reg[CH_RED]   <= box[15:8])  &&
                 (avg_reg[CH_GREEN] >= box[23:16]) && (avg_reg[CH_GREEN] <= box[31:24]) &&
                 (avg_reg[CH_BLUE]  >= box[39:32]) && (avg_reg[CH_BLUE]  <= box[47:40]);

    assign station = !((idx_reg == 4'd0) || (idx_reg == 4'd1));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                bounds_reg[i] <= BOUNDS_RESET[i];
            end
        end
        else if (cfg_valid && (cfg_index < 4'(NUM_REGS)))
        begin
            bounds_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // sequencer and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            sum_reg[2]    <= '0;
            win_pos_reg   <= '0;
            valid_cnt_reg <= '0;
            chan_reg      <= CH_RED;
            avg_phase_reg <= 1'b0;
            entry_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // drop the word once taken, unless a new one replaces it
            if (out_valid_reg && m_axis_tready && !((state_reg == ST_EMIT) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        chan_reg <= CH_RED;
                        if (s_axis_tdata[63:48] != 16'd0)
                        begin
                            avg_phase_reg <= 1'b0;
                            state_reg     <= ST_LOAD;
                        end
                        else if (pos_inc == WINDOW_LEN)
                        begin
                            win_pos_reg   <= pos_inc;
                            avg_phase_reg <= 1'b1;
                            state_reg     <= (valid_cnt_reg != 5'd0) ? ST_LOAD : ST_EMIT;
                        end
                        else
                        begin
                            win_pos_reg <= pos_inc;
                        end
                    end
                end
                ST_LOAD:
                begin
                    step_reg  <= TOP_STEP;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg - 4'd1;
                    if (chan_done)
                    begin
                        if (!avg_phase_reg)
                        begin
                            sum_reg[chan_reg] <= sum_reg[chan_reg] + {4'd0, q_val};
                        end
                        if (chan_reg != CH_BLUE)
                        begin
                            chan_reg  <= chan_reg + 2'd1;
                            state_reg <= ST_LOAD;
                        end
                        else if (avg_phase_reg)
                        begin
                            entry_reg <= '0;
                            state_reg <= ST_MATCH;
                        end
                        else
                        begin
                            valid_cnt_reg <= cnt_inc;
                            win_pos_reg   <= pos_inc;
                            chan_reg      <= CH_RED;
                            if (pos_inc == WINDOW_LEN)
                            begin
                                avg_phase_reg <= 1'b1;
                                state_reg     <= ST_LOAD;
                            end
                            else
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                ST_MATCH:
                begin
                    if (hit || (entry_reg == LAST_ENTRY))
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        entry_reg <= entry_reg + 3'd1;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        sum_reg[0]    <= '0;
                        sum_reg[1]    <= '0;
                        sum_reg[2]    <= '0;
                        win_pos_reg   <= '0;
                        valid_cnt_reg <= '0;
                        avg_phase_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    raw_reg[0] <= s_axis_tdata[15:0];
                    raw_reg[1] <= s_axis_tdata[31:16];
                    raw_reg[2] <= s_axis_tdata[47:32];
                    clear_reg  <= s_axis_tdata[63:48];
                    // empty window result
                    avg_reg[0] <= '0;
                    avg_reg[1] <= '0;
                    avg_reg[2] <= '0;
                    idx_reg    <= UNKNOWN_INDEX;
                end
            end
            ST_LOAD:
            begin
                rem_reg <= dividend;
                dvs_reg <= divisor;
                quo_reg <= '0;
            end
            ST_DIV:
            begin
                dvs_reg <= {1'b0, dvs_reg[23:1]};
                if (step_reg != TOP_STEP)
                begin
                    quo_reg <= {quo_reg[6:0], ge};
                    if (ge)
                    begin
                        rem_reg <= rem_sub;
                    end
                end
                if (chan_done && avg_phase_reg)
                begin
                    avg_reg[chan_reg] <= q_val;
                end
            end
            ST_MATCH:
            begin
                if (hit)
                begin
                    idx_reg <= {1'b0, entry_reg};
                end
                else if (entry_reg == LAST_ENTRY)
                begin
                    idx_reg <= UNKNOWN_INDEX;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_data_reg <= {6'd0, valid_cnt_reg, avg_reg[CH_BLUE],
                                     avg_reg[CH_GREEN], avg_reg[CH_RED], station, idx_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // a result word never carries an index above unknown
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:0] <= UNKNOWN_INDEX))
        else $error("color index out of range");

    // station flag follows the index
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4] ==
            !((m_axis_tdata[3:0] == 4'd0) || (m_axis_tdata[3:0] == 4'd1))))
        else $error("station flag does not match index");

    // the window never overruns while waiting for samples
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (win_pos_reg < WINDOW_LEN))
        else $error("window position overrun");

    // valid samples never outnumber samples taken
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_cnt_reg <= win_pos_reg)
        else $error("valid count above window position");

    // divide steps stay within the quotient width
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (step_reg <= TOP_STEP))
        else $error("divide step out of range");
`endif

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the RGB window color classifier
// Streams raw sensor words into the block, predicts each window's averages
// and color match in a small scoreboard, and checks every result word field
// by field while the configuration boxes are changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
    import rwcc_pkg::*;
();

    localparam int WINDOW_LEN    = 10;
    localparam int NUM_BOXES     = 8;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_WINDOWS = 10;

    // one classification result, laid out as in m_axis_tdata[33:0]
    typedef struct packed {
        logic [4:0] valid_samples;
        logic [7:0] avg_blue;
        logic [7:0] avg_green;
        logic [7:0] avg_red;
        logic       station_found;
        logic [3:0] color_index;
    } window_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: window predictor plus queue of expected results
    // ------------------------------------------------------------------------
    class color_window_scoreboard;
        bounds_t        box [NUM_REGS];
        logic [11:0]    sum_r, sum_g, sum_b;
        logic [4:0]     position, n_valid;
        window_result_t pending [$];
        int             n_errors, n_results, n_samples, n_empty;

        function new();
            foreach (box[k]) box[k] = BOUNDS_RESET[k];
            sum_r = '0;
            sum_g = '0;
            sum_b = '0;
            position = '0;
            n_valid = '0;
            n_errors = 0;
            n_results = 0;
            n_samples = 0;
            n_empty = 0;
        endfunction

        // floor(raw*255/clear), saturated at full scale
        static function logic [7:0] scaled(logic [15:0] raw, logic [15:0] clr);
            logic [23:0] q;
            q = ({8'd0, raw} * 24'd255) / {8'd0, clr};
            return (q > 24'd255) ? FULL_SCALE : q[7:0];
        endfunction

        static function bit in_box(bounds_t bx, logic [7:0] r, logic [7:0] g,
                                   logic [7:0] b);
            return r >= bx[7:0]   && r <= bx[15:8]  &&
                   g >= bx[23:16] && g <= bx[31:24] &&
                   b >= bx[39:32] && b <= bx[47:40];
        endfunction

        function void note_config(logic [3:0] idx, bounds_t val);
            if (idx < NUM_REGS)
                box[idx[2:0]] = val;
        endfunction

        function void note_sample(logic [63:0] w);
            logic [15:0]    r, g, b, c;
            window_result_t res;
            bit             found;
            r = w[15:0];
            g = w[31:16];
            b = w[47:32];
            c = w[63:48];
            n_samples++;
            if (c != 16'd0)
            begin
                sum_r = sum_r + scaled(r, c);
                sum_g = sum_g + scaled(g, c);
                sum_b = sum_b + scaled(b, c);
                n_valid = n_valid + 5'd1;
            end
            position = position + 5'd1;
            if (position < WINDOW_LEN)
                return;

            // window closes: averages, then first box that holds them
            res = '0;
            res.color_index = UNKNOWN_INDEX;
            found = 1'b0;
            if (n_valid != 5'd0)
            begin
                res.avg_red   = 8'(sum_r / n_valid);
                res.avg_green = 8'(sum_g / n_valid);
                res.avg_blue  = 8'(sum_b / n_valid);
                for (int k = 0; k < NUM_BOXES && k < NUM_REGS; k++)
                begin
                    if (!found && in_box(box[k], res.avg_red, res.avg_green,
                                         res.avg_blue))
                    begin
                        res.color_index = 4'(k);
                        found = 1'b1;
                    end
                end
            end
            else
                n_empty++;
            res.station_found = !(res.color_index == 4'd0 || res.color_index == 4'd1);
            res.valid_samples = n_valid;
            pending.push_back(res);
            sum_r = '0;
            sum_g = '0;
            sum_b = '0;
            position = '0;
            n_valid = '0;
        endfunction

        function void cmp_field(string name, int want, int got);
            if (want != got)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("MISMATCH result %0d %s: expected %0d, got %0d",
                             n_results, name, want, got);
            end
        endfunction

        function void check_result(logic [39:0] w);
            window_result_t got, want;
            got = w[33:0];
            if (pending.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("MISMATCH unexpected result word %h", w);
                return;
            end
            want = pending.pop_front();
            cmp_field("color_index", want.color_index, got.color_index);
            cmp_field("station_found", want.station_found, got.station_found);
            cmp_field("avg_red", want.avg_red, got.avg_red);
            cmp_field("avg_green", want.avg_green, got.avg_green);
            cmp_field("avg_blue", want.avg_blue, got.avg_blue);
            cmp_field("valid_samples", want.valid_samples, got.valid_samples);
            cmp_field("pad", 0, w[39:34]);
            n_results++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and block under test
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;     // raw_red, raw_green, raw_blue, raw_clear
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;     // color_index, station_found, avg_red,
                                   // avg_green, avg_blue, valid_samples, pad
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [47:0] cfg_data;

    color_window_scoreboard sb;
    bit  idle_on;
    bit  hold_req;
    int  hold_len;
    int  cycles;
    int  n_cfg_writes;

    rgb_window_color_classifier_unit #(
        .SAMPLES_PER_WINDOW (WINDOW_LEN),
        .COLOR_ENTRIES      (NUM_BOXES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // result receiver: random stalls, plus one long hold on request
    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // drive tasks
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [63:0] w);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_sample(w);
    endtask

    task automatic write_box(input logic [3:0] idx, input bounds_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.note_config(idx, val);
        n_cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for all expected results, then let any sample in flight finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic bounds_t random_box();
        bounds_t v;
        int      lo, hi, tmp;
        v = '0;
        case ($urandom_range(0, 7))
            0: v = '1;
            1: v = '0;
            2: v = 48'hFF00_FF00_FF00;
            3: v = BOUNDS_RESET[$urandom_range(0, NUM_REGS - 1)];
            4: v = 48'({$urandom, $urandom});
            default:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    lo = $urandom_range(0, 255);
                    hi = lo + $urandom_range(0, 90);
                    if (hi > 255)
                        hi = 255;
                    // occasional inverted box
                    if ($urandom_range(0, 7) == 0)
                    begin
                        tmp = lo;
                        lo = hi + 1;
                        hi = tmp;
                        if (lo > 255)
                            lo = 255;
                    end
                    v[16*j +: 8]     = 8'(lo);
                    v[16*j + 8 +: 8] = 8'(hi);
                end
            end
        endcase
        return v;
    endfunction

    // raw count whose normalized value lands near lvl for this clear count
    function automatic logic [15:0] raw_near(int lvl, int clr);
        int v;
        v = (lvl * clr + $urandom_range(0, 254)) / 255;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    // one window of samples; style picks noise, empty or aimed at a box
    task automatic send_window();
        int          style, k, t_r, t_g, t_b, clr, ch;
        bounds_t     bx;
        logic [15:0] r, g, b;
        logic [63:0] w;
        style = $urandom_range(0, 9);
        k = $urandom_range(0, NUM_REGS - 1);
        bx = sb.box[k];
        t_r = $urandom_range(bx[7:0], bx[15:8]);
        t_g = $urandom_range(bx[23:16], bx[31:24]);
        t_b = $urandom_range(bx[39:32], bx[47:40]);
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            if (style == 0)
            begin
                w = {$urandom, $urandom};
                if ($urandom_range(0, 3) == 0)
                    w[63:48] = 16'd0;
            end
            else if (style == 1)
            begin
                w = {16'd0, 16'($urandom_range(0, 65535)), $urandom};
            end
            else
            begin
                clr = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                   : $urandom_range(256, 65535);
                r = raw_near(t_r, clr);
                g = raw_near(t_g, clr);
                b = raw_near(t_b, clr);
                // bright channel now and then
                if ($urandom_range(0, 11) == 0 && clr < 65535)
                begin
                    ch = $urandom_range(0, 2);
                    if (ch == CH_RED)
                        r = 16'($urandom_range(clr + 1, 65535));
                    else if (ch == CH_GREEN)
                        g = 16'($urandom_range(clr + 1, 65535));
                    else
                        b = 16'($urandom_range(clr + 1, 65535));
                end
                w = {clr[15:0], b, g, r};
                if ($urandom_range(0, 9) == 0)
                    w[63:48] = 16'd0;
            end
            send_sample(w);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        idle_on = 1'b0;
        hold_req = 1'b0;
        hold_len = 0;
        cycles = 0;
        n_cfg_writes = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // directed: field extremes and bright channels on reset boxes
        send_sample({16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_sample({16'hFFFF, 16'h0000, 16'h0000, 16'h0000});
        send_sample({16'hFFFF, 16'h8000, 16'h0000, 16'hFFFF});
        send_sample({16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_sample({16'h0001, 16'h0003, 16'h0002, 16'h0001});
        send_sample({16'h8000, 16'hFF00, 16'h00FF, 16'h1234});
        send_sample({16'd1000, 16'd30, 16'd20, 16'd10});
        send_sample({16'd1000, 16'd30, 16'd20, 16'd10});
        send_sample({16'd1000, 16'd30, 16'd20, 16'd10});
        send_sample({16'd1000, 16'd30, 16'd20, 16'd10});
        // empty window: no valid sample at all
        for (int i = 0; i < WINDOW_LEN; i++)
            send_sample({16'd0, i[0] ? 48'hFFFF_FFFF_FFFF : 48'd0});
        // a white window: every channel at or above clear
        for (int i = 0; i < WINDOW_LEN; i++)
            send_sample({16'd5000, 16'd5000, 16'hFFFF, 16'd6000});
        drain();

        // ignored indexes and an inverted red range on box 0
        write_box(4'd9, 48'h0123_4567_89AB);
        write_box(4'd15, '1);
        write_box(4'd0, 48'hFF00_FF00_00FF);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                for (int k = 0; k < NUM_REGS; k++)
                begin
                    if (p == 1)
                        write_box(4'(k), 48'hFF00_FF00_FF00);
                    else if (p == 2)
                        write_box(4'(k), k[0] ? '1 : '0);
                    else if (p == NUM_PHASES - 1)
                        write_box(4'(k), BOUNDS_RESET[k]);
                    else
                        write_box(4'(k), random_box());
                end
            end
            for (int wnd = 0; wnd < PHASE_WINDOWS; wnd++)
            begin
                idle_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
                // long output hold while samples keep coming
                if (p == 3 && wnd == 2)
                begin
                    hold_len = 600;
                    hold_req = 1'b1;
                end
                send_window();
            end
            drain();
        end

        $display("Ran %0d samples in %0d windows (%0d with no valid sample),",
                 sb.n_samples, sb.n_results, sb.n_empty);
        $display("with %0d box register writes across %0d box settings.",
                 n_cfg_writes, NUM_PHASES + 1);
        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: rgb_window_color_classifier_unit.f
rtl/rwcc_pkg.sv
rtl/rgb_window_color_classifier_unit.sv
test/tb.sv
